>>> rtl/spq_pkg.sv
// ============================================================================
// spq_pkg: shared types and constants of the stable priority ready queue
// Opcodes, status codes, cell actions and commands, fixed field widths and defaults.
// ============================================================================
package spq_pkg;

    // Fixed field widths of the command and result ports
    localparam int TAG_W       = 5;
    localparam int PRIO_PORT_W = 8;
    localparam int OPCODE_W    = 2;
    localparam int STATUS_W    = 2;

    // Defaults of the top-level parameters
    localparam int DEF_QUEUE_DEPTH   = 32;
    localparam int DEF_PRIORITY_BITS = 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_REPRIO = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // Action that every cell of the chain takes on the broadcast command
    typedef enum logic [1:0] {
        ACT_HOLD   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2
    } t_act;

    // Command broadcast to all cells (priority travels beside it)
    typedef struct packed {
        t_act             act;
        logic [TAG_W-1:0] tag;
    } t_cell_cmd;

endpackage

>>> rtl/spq_cell.sv
// ============================================================================
// spq_cell: one slot of the sorted queue chain
// Holds a tag and a priority; on insert it keeps, loads the new entry or takes
// its upper neighbor; on remove it takes its lower neighbor from the first
// matching slot on.
// ============================================================================
module spq_cell
    import spq_pkg::*;
#(
    parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
) (
    input  logic                     i_clk,
    input  t_cell_cmd                i_cmd,
    input  logic [PRIORITY_BITS-1:0] i_cmd_prio,
    input  logic                     i_valid,
    input  logic                     i_keep,
    input  logic                     i_keep_prev,
    input  logic                     i_seen_in,
    input  logic [TAG_W-1:0]         i_prev_tag,
    input  logic [PRIORITY_BITS-1:0] i_prev_prio,
    input  logic [TAG_W-1:0]         i_next_tag,
    input  logic [PRIORITY_BITS-1:0] i_next_prio,
    output logic [TAG_W-1:0]         o_tag,
    output logic [PRIORITY_BITS-1:0] o_prio,
    output logic                     o_seen,
    output logic                     o_first
);

    logic [TAG_W-1:0]         r_tag;
    logic [PRIORITY_BITS-1:0] r_prio;
    logic [TAG_W-1:0]         n_tag;
    logic [PRIORITY_BITS-1:0] n_prio;
    logic                     hit;

    // Match this slot against the tag being searched
    assign hit     = i_valid && (r_tag == i_cmd.tag);
    assign o_seen  = i_seen_in || hit;
    assign o_first = hit && !i_seen_in;

    // Select the slot content for the next cycle
    always_comb begin
        n_tag  = r_tag;
        n_prio = r_prio;
        unique case (i_cmd.act)
            ACT_INSERT: begin
                if (!i_keep) begin
                    if (i_keep_prev) begin
                        n_tag  = i_cmd.tag;
                        n_prio = i_cmd_prio;
                    end else begin
                        n_tag  = i_prev_tag;
                        n_prio = i_prev_prio;
                    end
                end
            end
            ACT_REMOVE: begin
                if (o_seen) begin
                    n_tag  = i_next_tag;
                    n_prio = i_next_prio;
                end
            end
            default: begin
            end
        endcase
    end

    // Slot payload needs no reset: slots beyond the fill level are never read
    always_ff @(posedge i_clk) begin
        r_tag  <= n_tag;
        r_prio <= n_prio;
    end

    assign o_tag  = r_tag;
    assign o_prio = r_prio;

endmodule

>>> rtl/stable_priority_ready_queue_top.sv
// ============================================================================
// stable_priority_ready_queue_top: sorted ready queue of thread tags
// A chain of slot cells kept in descending priority order, FIFO within a
// priority, with insert, pop, remove and reprioritize commands.
// ============================================================================
// Usage:
//   Drive the command fields and raise start; the transaction is taken at a
//   clock edge where start is high and busy is low. The fields are captured
//   then, so they may change afterwards.
//   Each command yields one result, shown for one cycle with o_done high.
//   The receiver cannot hold results off; it must take them in that cycle.
// Sequencing:
//   Insert, pop and remove pass from S_IDLE through S_FIND; o_done is
//   registered from S_FIND, and a new command may be accepted in the
//   o_done cycle. Reprioritize that moves the tag adds S_PLACE (remove,
//   then insert); unchanged priority or absent tag ends in S_FIND.
//   The state machine sets the command rate; the slot chain performs one shift per cycle.
// Reset:
//   Synchronous, active low. Empties the queue and drops any command in
//   flight; slot contents are left as they are and are never read.
// ============================================================================
module stable_priority_ready_queue_top
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
    parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
    localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [OPCODE_W-1:0]    i_opcode,
    input  logic [TAG_W-1:0]       i_thread_tag,
    input  logic [PRIO_PORT_W-1:0] i_priority_req,
    input  logic                   i_running_valid,
    input  logic [PRIO_PORT_W-1:0] i_running_priority,
    output logic                   o_done,
    output logic [STATUS_W-1:0]    o_status,
    output logic [TAG_W-1:0]       o_popped_tag,
    output logic                   o_head_valid,
    output logic [PRIO_PORT_W-1:0] o_head_priority,
    output logic [CNT_W-1:0]       o_entry_count,
    output logic                   o_should_preempt
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FIND  = 3'b010,
        S_PLACE = 3'b100
    } t_state;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_done, n_done;
    t_status                  r_status, n_status;
    logic [TAG_W-1:0]         r_popped, n_popped;

    t_opcode                  r_op;
    logic [TAG_W-1:0]         r_tag;
    logic [PRIORITY_BITS-1:0] r_prio;
    logic                     r_run_valid;
    logic [PRIORITY_BITS-1:0] r_run_prio;

    t_cell_cmd                cmd;
    logic                     seen_seed;
    logic                     found;
    logic                     full;
    logic                     empty;
    logic [PRIORITY_BITS-1:0] old_prio;
    logic [PRIORITY_BITS-1:0] head_prio;

    logic [TAG_W-1:0]         cell_tag   [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] cell_prio  [QUEUE_DEPTH];
    logic                     cell_valid [QUEUE_DEPTH];
    logic                     cell_keep  [QUEUE_DEPTH];
    logic                     cell_first [QUEUE_DEPTH];
    logic                     seen_chain [QUEUE_DEPTH+1];

    assign full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign empty = (r_count == '0);
    assign found = seen_chain[QUEUE_DEPTH];
    assign seen_chain[0] = seen_seed;

    // Build the slot chain
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic [TAG_W-1:0]         prev_tag, next_tag;
        logic [PRIORITY_BITS-1:0] prev_prio, next_prio;
        logic                     keep_prev;

        assign cell_valid[i] = (CNT_W'(i) < r_count);
        assign cell_keep[i]  = cell_valid[i] && (cell_prio[i] >= r_prio);

        if (i == 0) begin : g_head
            assign prev_tag  = '0;
            assign prev_prio = '0;
            assign keep_prev = 1'b1;
        end else begin : g_inner
            assign prev_tag  = cell_tag[i-1];
            assign prev_prio = cell_prio[i-1];
            assign keep_prev = cell_keep[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign next_tag  = '0;
            assign next_prio = '0;
        end else begin : g_body
            assign next_tag  = cell_tag[i+1];
            assign next_prio = cell_prio[i+1];
        end

        spq_cell #(
            .PRIORITY_BITS(PRIORITY_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (cmd),
            .i_cmd_prio (r_prio),
            .i_valid    (cell_valid[i]),
            .i_keep     (cell_keep[i]),
            .i_keep_prev(keep_prev),
            .i_seen_in  (seen_chain[i]),
            .i_prev_tag (prev_tag),
            .i_prev_prio(prev_prio),
            .i_next_tag (next_tag),
            .i_next_prio(next_prio),
            .o_tag      (cell_tag[i]),
            .o_prio     (cell_prio[i]),
            .o_seen     (seen_chain[i+1]),
            .o_first    (cell_first[i])
        );
    end

    // Pick the priority of the first matching slot
    always_comb begin
        old_prio = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            old_prio = old_prio | (cell_first[i] ? cell_prio[i] : '0);
        end
    end

    // Sequence the command through the chain
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_done    = 1'b0;
        n_status  = r_status;
        n_popped  = r_popped;
        cmd.act   = ACT_HOLD;
        cmd.tag   = r_tag;
        seen_seed = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                n_state  = S_IDLE;
                n_done   = 1'b1;
                n_status = ST_OK;
                n_popped = '0;
                unique case (r_op)
                    OP_INSERT: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            cmd.act = ACT_INSERT;
                            n_count = r_count + 1'b1;
                        end
                    end
                    OP_POP: begin
                        seen_seed = 1'b1;
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            cmd.act  = ACT_REMOVE;
                            n_count  = r_count - 1'b1;
                            n_popped = cell_tag[0];
                        end
                    end
                    OP_REMOVE: begin
                        if (!found) begin
                            n_status = ST_NOT_FOUND;
                        end else begin
                            cmd.act = ACT_REMOVE;
                            n_count = r_count - 1'b1;
                        end
                    end
                    OP_REPRIO: begin
                        if (!found) begin
                            n_status = ST_NOT_FOUND;
                        end else if (old_prio != r_prio) begin
                            // Take the tag out now, place it next cycle
                            cmd.act = ACT_REMOVE;
                            n_count = r_count - 1'b1;
                            n_state = S_PLACE;
                            n_done  = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_PLACE: begin
                cmd.act = ACT_INSERT;
                n_count = r_count + 1'b1;
                n_state = S_IDLE;
                n_done  = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Capture the transaction and hold the result fields
    always_ff @(posedge i_clk) begin
        if (start && r_state == S_IDLE) begin
            r_op        <= t_opcode'(i_opcode);
            r_tag       <= i_thread_tag;
            r_prio      <= PRIORITY_BITS'(i_priority_req);
            r_run_valid <= i_running_valid;
            r_run_prio  <= PRIORITY_BITS'(i_running_priority);
        end
        r_status <= n_status;
        r_popped <= n_popped;
    end

    // Report the head, read from the slot chain as it stands after the command
    assign head_prio        = empty ? '0 : cell_prio[0];
    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_popped_tag     = r_popped;
    assign o_head_valid     = !empty;
    assign o_head_priority  = PRIO_PORT_W'(head_prio);
    assign o_entry_count    = r_count;
    assign o_should_preempt = !empty && r_run_valid && (r_run_prio < head_prio);

    // A result follows only a command in flight
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a command in flight");

    // A full report comes only from a full queue
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_FULL) |-> (o_entry_count == CNT_W'(QUEUE_DEPTH)))
        else $error("full status with room left");

    // An empty report leaves no head
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_EMPTY) |-> (!o_head_valid && !o_should_preempt))
        else $error("empty status with a head present");

    // An accepted command raises busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

endmodule
